FILE: rtl/core/smc_pkg.sv
// ----------------------------------------------------------------------------
// smc_pkg
// Shared types, constants and arithmetic helpers for the stereo matching cost
// block: job format between the front and back parts, luma weights, cost
// weights and the reciprocal used for the final division by 75.
// ----------------------------------------------------------------------------
package smc_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WIDTH_W    = COL_W + 1;
    localparam int DISP_W     = 8;
    localparam int PIX_W      = 24;
    localparam int LUMA_W     = 16;
    localparam int GRAD_W     = 17;
    localparam int COST_W     = 14;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic REG_DISPARITY   = 1'b0;
    localparam logic REG_IMAGE_WIDTH = 1'b1;

    localparam logic [15:0] LUMA_KR    = 16'd19595;
    localparam logic [15:0] LUMA_KG    = 16'd38470;
    localparam logic [15:0] LUMA_KB    = 16'd7471;
    localparam logic [7:0]  LUMA_ROUND = 8'd128;

    localparam logic [4:0]  RGB_SUM_CAP   = 5'd30;
    localparam logic [9:0]  GRAD_DIFF_CAP = 10'd512;
    localparam logic [11:0] COST_K_RGB    = 12'd2816;
    localparam logic [8:0]  COST_K_GRAD   = 9'd267;
    localparam logic [5:0]  COST_ROUND    = 6'd37;
    localparam int          NUM_W         = 20;
    localparam logic [19:0] DIV75_MUL     = 20'd894785;
    localparam int          DIV75_SHIFT   = 26;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic signed [GRAD_W-1:0] grad_t;

    typedef struct packed {
        pix_t              left_pix;
        grad_t             left_grad;
        pix_t              right_pix;
        grad_t             right_grad;
        logic [COL_W-1:0]  col;
        logic              done;
    } job_t;

    typedef struct packed {
        pix_t  right_pix;
        grad_t right_grad;
    } entry_t;

    function automatic logic [LUMA_W-1:0] luma(input pix_t pix);
        logic [23:0] acc;
        acc = 24'(LUMA_KR) * 24'(pix[7:0])
            + 24'(LUMA_KG) * 24'(pix[15:8])
            + 24'(LUMA_KB) * 24'(pix[23:16])
            + 24'(LUMA_ROUND);
        return acc[23:8];
    endfunction

    function automatic logic [7:0] absdiff8(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

FILE: rtl/core/smc_front.sv
// ----------------------------------------------------------------------------
// smc_front
// Accepts pixel pairs, tracks the column within the row, forms luma and the
// horizontal gradients, and issues zero, one or two cost jobs per item.
// ----------------------------------------------------------------------------
module smc_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [7:0]                  s_left_red,
    input  logic [7:0]                  s_left_green,
    input  logic [7:0]                  s_left_blue,
    input  logic [7:0]                  s_right_red,
    input  logic [7:0]                  s_right_green,
    input  logic [7:0]                  s_right_blue,
    input  logic [smc_pkg::WIDTH_W-1:0] image_width,
    input  logic                        space_ok,
    output logic [1:0]                  push_n,
    output smc_pkg::job_t               push_job [2]
);

    logic                        adv;
    logic [smc_pkg::WIDTH_W-1:0] w_eff;
    logic [smc_pkg::COL_W-1:0]   col_cur;
    logic                        col_last;
    logic [smc_pkg::COL_W-1:0]   count_reg;
    logic [smc_pkg::COL_W-1:0]   count_next;

    logic                        a_valid_reg;
    smc_pkg::pix_t               a_lpix_reg;
    smc_pkg::pix_t               a_rpix_reg;
    logic [smc_pkg::COL_W-1:0]   a_col_reg;
    logic                        a_last_reg;

    logic                        b_valid_reg;
    smc_pkg::pix_t               b_lpix_reg;
    smc_pkg::pix_t               b_rpix_reg;
    logic [smc_pkg::LUMA_W-1:0]  b_ll_reg;
    logic [smc_pkg::LUMA_W-1:0]  b_rl_reg;
    logic [smc_pkg::COL_W-1:0]   b_col_reg;
    logic                        b_last_reg;

    logic [smc_pkg::LUMA_W-1:0]  l_hist0_reg;
    logic [smc_pkg::LUMA_W-1:0]  l_hist1_reg;
    logic [smc_pkg::LUMA_W-1:0]  r_hist0_reg;
    logic [smc_pkg::LUMA_W-1:0]  r_hist1_reg;
    smc_pkg::pix_t               pend_lpix_reg;
    smc_pkg::pix_t               pend_rpix_reg;

    smc_pkg::grad_t              l_end;
    smc_pkg::grad_t              r_end;
    smc_pkg::grad_t              l_wide;
    smc_pkg::grad_t              r_wide;
    logic signed [smc_pkg::GRAD_W:0] l_sum;
    logic signed [smc_pkg::GRAD_W:0] r_sum;
    smc_pkg::grad_t              l_prev;
    smc_pkg::grad_t              r_prev;
    smc_pkg::job_t               job_prev;
    smc_pkg::job_t               job_last;
    logic                        has_prev;

    assign adv     = space_ok;
    assign s_ready = adv;

    always_comb begin
        priority if (image_width < smc_pkg::WIDTH_W'(2)) begin
            w_eff = smc_pkg::WIDTH_W'(2);
        end else if (image_width > smc_pkg::WIDTH_W'(smc_pkg::MAX_WIDTH)) begin
            w_eff = smc_pkg::WIDTH_W'(smc_pkg::MAX_WIDTH);
        end else begin
            w_eff = image_width;
        end
        col_cur    = ({1'b0, count_reg} >= w_eff) ? '0 : count_reg;
        col_last   = ({1'b0, col_cur} + smc_pkg::WIDTH_W'(1)) >= w_eff;
        count_next = col_last ? '0 : col_cur + smc_pkg::COL_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (adv) begin
            if (s_valid) begin
                count_reg <= count_next;
            end
            a_valid_reg <= s_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_lpix_reg <= {s_left_blue, s_left_green, s_left_red};
            a_rpix_reg <= {s_right_blue, s_right_green, s_right_red};
            a_col_reg  <= col_cur;
            a_last_reg <= col_last;
            b_lpix_reg <= a_lpix_reg;
            b_rpix_reg <= a_rpix_reg;
            b_ll_reg   <= smc_pkg::luma(a_lpix_reg);
            b_rl_reg   <= smc_pkg::luma(a_rpix_reg);
            b_col_reg  <= a_col_reg;
            b_last_reg <= a_last_reg;
            if (b_valid_reg) begin
                l_hist1_reg   <= l_hist0_reg;
                l_hist0_reg   <= b_ll_reg;
                r_hist1_reg   <= r_hist0_reg;
                r_hist0_reg   <= b_rl_reg;
                pend_lpix_reg <= b_lpix_reg;
                pend_rpix_reg <= b_rpix_reg;
            end
        end
    end

    always_comb begin
        l_end  = $signed({1'b0, b_ll_reg}) - $signed({1'b0, l_hist0_reg});
        r_end  = $signed({1'b0, b_rl_reg}) - $signed({1'b0, r_hist0_reg});
        l_wide = $signed({1'b0, b_ll_reg}) - $signed({1'b0, l_hist1_reg});
        r_wide = $signed({1'b0, b_rl_reg}) - $signed({1'b0, r_hist1_reg});
        l_sum  = $signed({l_wide[smc_pkg::GRAD_W-1], l_wide}) + 18'sd1;
        r_sum  = $signed({r_wide[smc_pkg::GRAD_W-1], r_wide}) + 18'sd1;
        if (b_col_reg == smc_pkg::COL_W'(1)) begin
            l_prev = l_end;
            r_prev = r_end;
        end else begin
            l_prev = smc_pkg::GRAD_W'(l_sum >>> 1);
            r_prev = smc_pkg::GRAD_W'(r_sum >>> 1);
        end

        job_prev.left_pix   = pend_lpix_reg;
        job_prev.left_grad  = l_prev;
        job_prev.right_pix  = pend_rpix_reg;
        job_prev.right_grad = r_prev;
        job_prev.col        = b_col_reg - smc_pkg::COL_W'(1);
        job_prev.done       = 1'b0;

        job_last.left_pix   = b_lpix_reg;
        job_last.left_grad  = l_end;
        job_last.right_pix  = b_rpix_reg;
        job_last.right_grad = r_end;
        job_last.col        = b_col_reg;
        job_last.done       = 1'b1;

        has_prev    = b_col_reg != '0;
        push_job[0] = has_prev ? job_prev : job_last;
        push_job[1] = job_last;
        if (adv && b_valid_reg) begin
            push_n = {1'b0, has_prev} + {1'b0, b_last_reg};
        end else begin
            push_n = 2'd0;
        end
    end

endmodule

FILE: rtl/core/smc_job_fifo.sv
// ----------------------------------------------------------------------------
// smc_job_fifo
// Short register queue between front and back: takes up to two jobs per
// cycle, releases one per cycle whenever the back end pops.
// ----------------------------------------------------------------------------
module smc_job_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [1:0]    push_n,
    input  smc_pkg::job_t push_job [2],
    output logic          space_ok,
    output logic          head_valid,
    output smc_pkg::job_t head_job,
    input  logic          pop
);

    smc_pkg::job_t                fifo_mem [smc_pkg::FIFO_DEPTH];
    logic [smc_pkg::FIFO_AW-1:0]  wr_ptr_reg;
    logic [smc_pkg::FIFO_AW-1:0]  wr_ptr_next;
    logic [smc_pkg::FIFO_AW-1:0]  wr_ptr_inc;
    logic [smc_pkg::FIFO_AW-1:0]  rd_ptr_reg;
    logic [smc_pkg::FIFO_AW-1:0]  rd_ptr_next;
    logic [smc_pkg::FIFO_AW:0]    count_reg;
    logic [smc_pkg::FIFO_AW:0]    count_next;

    assign wr_ptr_inc  = wr_ptr_reg + smc_pkg::FIFO_AW'(1);
    assign wr_ptr_next = wr_ptr_reg + smc_pkg::FIFO_AW'(push_n);
    assign rd_ptr_next = rd_ptr_reg + smc_pkg::FIFO_AW'(pop);
    assign count_next  = count_reg + (smc_pkg::FIFO_AW + 1)'(push_n)
                       - (smc_pkg::FIFO_AW + 1)'(pop);

    assign space_ok   = count_reg <= (smc_pkg::FIFO_AW + 1)'(smc_pkg::FIFO_DEPTH - 2);
    assign head_valid = count_reg != '0;
    assign head_job   = fifo_mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            fifo_mem[wr_ptr_reg] <= push_job[0];
        end
        if (push_n == 2'd2) begin
            fifo_mem[wr_ptr_inc] <= push_job[1];
        end
    end

endmodule

FILE: rtl/core/smc_back.sv
// ----------------------------------------------------------------------------
// smc_back
// Writes each job's right pixel and gradient into the row store, reads the
// matched right column and computes the truncated cost, then holds the
// result in the output register.
// ----------------------------------------------------------------------------
module smc_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [smc_pkg::DISP_W-1:0] disparity,
    input  logic                       head_valid,
    input  smc_pkg::job_t              head_job,
    output logic                       pop,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [smc_pkg::COST_W-1:0] m_match_cost,
    output logic [smc_pkg::COL_W-1:0]  m_cost_column,
    output logic                       m_row_done
);

    smc_pkg::entry_t              row_mem [smc_pkg::MAX_WIDTH];
    smc_pkg::entry_t              rd_data_reg;
    smc_pkg::entry_t              own_entry;
    logic                         adv;
    logic [smc_pkg::COL_W-1:0]    where;

    logic                         x_valid_reg;
    smc_pkg::job_t                x_job_reg;
    logic                         x_bypass_reg;
    smc_pkg::entry_t              x_entry;
    logic [9:0]                   x_rgb_sum;
    logic signed [smc_pkg::GRAD_W:0] x_gdiff;
    logic [smc_pkg::GRAD_W:0]     x_gabs;

    logic                         y_valid_reg;
    logic [4:0]                   y_s_reg;
    logic [9:0]                   y_g_reg;
    logic [smc_pkg::COL_W-1:0]    y_col_reg;
    logic                         y_done_reg;

    logic                         z_valid_reg;
    logic [smc_pkg::NUM_W-1:0]    z_num_reg;
    logic [smc_pkg::COL_W-1:0]    z_col_reg;
    logic                         z_done_reg;
    logic [2*smc_pkg::NUM_W-1:0]  z_prod;

    logic                         m_valid_reg;
    logic [smc_pkg::COST_W-1:0]   m_cost_reg;
    logic [smc_pkg::COL_W-1:0]    m_col_reg;
    logic                         m_done_reg;

    assign adv = !m_valid_reg || m_ready;
    assign pop = head_valid && adv;

    assign where = (head_job.col >= smc_pkg::COL_W'(disparity))
                 ? head_job.col - smc_pkg::COL_W'(disparity) : '0;

    assign own_entry.right_pix  = head_job.right_pix;
    assign own_entry.right_grad = head_job.right_grad;

    always_ff @(posedge aclk) begin
        if (pop) begin
            row_mem[head_job.col] <= own_entry;
            rd_data_reg           <= row_mem[where];
        end
    end

    always_comb begin
        x_entry.right_pix  = x_bypass_reg ? x_job_reg.right_pix : rd_data_reg.right_pix;
        x_entry.right_grad = x_bypass_reg ? x_job_reg.right_grad : rd_data_reg.right_grad;
        x_rgb_sum = 10'(smc_pkg::absdiff8(x_job_reg.left_pix[7:0], x_entry.right_pix[7:0]))
                  + 10'(smc_pkg::absdiff8(x_job_reg.left_pix[15:8], x_entry.right_pix[15:8]))
                  + 10'(smc_pkg::absdiff8(x_job_reg.left_pix[23:16], x_entry.right_pix[23:16]));
        x_gdiff = $signed({x_job_reg.left_grad[smc_pkg::GRAD_W-1], x_job_reg.left_grad})
                - $signed({x_entry.right_grad[smc_pkg::GRAD_W-1], x_entry.right_grad});
        x_gabs  = x_gdiff[smc_pkg::GRAD_W] ? (smc_pkg::GRAD_W + 1)'(-x_gdiff)
                                           : (smc_pkg::GRAD_W + 1)'(x_gdiff);
        z_prod  = (2 * smc_pkg::NUM_W)'(z_num_reg) * (2 * smc_pkg::NUM_W)'(smc_pkg::DIV75_MUL);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_valid_reg <= 1'b0;
            y_valid_reg <= 1'b0;
            z_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            x_valid_reg <= pop;
            y_valid_reg <= x_valid_reg;
            z_valid_reg <= y_valid_reg;
            m_valid_reg <= z_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x_job_reg    <= head_job;
            x_bypass_reg <= where == head_job.col;

            y_s_reg    <= (x_rgb_sum > 10'(smc_pkg::RGB_SUM_CAP))
                        ? smc_pkg::RGB_SUM_CAP : x_rgb_sum[4:0];
            y_g_reg    <= (x_gabs > (smc_pkg::GRAD_W + 1)'(smc_pkg::GRAD_DIFF_CAP))
                        ? smc_pkg::GRAD_DIFF_CAP : x_gabs[9:0];
            y_col_reg  <= x_job_reg.col;
            y_done_reg <= x_job_reg.done;

            z_num_reg  <= ((smc_pkg::NUM_W'(y_s_reg) * smc_pkg::NUM_W'(smc_pkg::COST_K_RGB)
                         + smc_pkg::NUM_W'(y_g_reg) * smc_pkg::NUM_W'(smc_pkg::COST_K_GRAD)) << 2)
                        + smc_pkg::NUM_W'(smc_pkg::COST_ROUND);
            z_col_reg  <= y_col_reg;
            z_done_reg <= y_done_reg;

            m_cost_reg <= z_prod[smc_pkg::DIV75_SHIFT +: smc_pkg::COST_W];
            m_col_reg  <= z_col_reg;
            m_done_reg <= z_done_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_match_cost  = m_cost_reg;
    assign m_cost_column = m_col_reg;
    assign m_row_done    = m_done_reg;

endmodule

FILE: rtl/core/stereo_matching_cost.sv
// ----------------------------------------------------------------------------
// stereo_matching_cost
// Per-pixel stereo matching cost for one disparity: truncated RGB absolute
// difference plus truncated luma gradient difference, streamed row by row.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid/s_ready    left and right RGB of one column
//   m_        out        m_valid/m_ready    match_cost, cost_column, row_done
//   cfg_      in         cfg_wr_en          cfg_index, cfg_wr_data
//
// One pixel pair per cycle sustained while m_ready is high. The cost that a
// pair completes passes front registers a and b, the job queue and back
// registers x, y, z and m before m_valid shows it; the last column of a row
// yields two costs, absorbed by the four-entry job queue, which holds s_ready
// low while it holds more than two jobs. The whole back end stalls on m_ready.
// Reset clears control state only; the row store needs no clearing pass.
// ----------------------------------------------------------------------------
module stereo_matching_cost (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [7:0]                  s_left_red,
    input  logic [7:0]                  s_left_green,
    input  logic [7:0]                  s_left_blue,
    input  logic [7:0]                  s_right_red,
    input  logic [7:0]                  s_right_green,
    input  logic [7:0]                  s_right_blue,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [smc_pkg::COST_W-1:0]  m_match_cost,
    output logic [smc_pkg::COL_W-1:0]   m_cost_column,
    output logic                        m_row_done,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_index,
    input  logic [smc_pkg::WIDTH_W-1:0] cfg_wr_data
);

    logic [smc_pkg::DISP_W-1:0]  disparity_reg;
    logic [smc_pkg::WIDTH_W-1:0] image_width_reg;

    logic                        space_ok;
    logic [1:0]                  push_n;
    smc_pkg::job_t               push_job [2];
    logic                        head_valid;
    smc_pkg::job_t               head_job;
    logic                        pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            disparity_reg   <= '0;
            image_width_reg <= smc_pkg::WIDTH_W'(smc_pkg::MAX_WIDTH);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                smc_pkg::REG_DISPARITY:   disparity_reg   <= cfg_wr_data[smc_pkg::DISP_W-1:0];
                smc_pkg::REG_IMAGE_WIDTH: image_width_reg <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    smc_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_left_red    (s_left_red),
        .s_left_green  (s_left_green),
        .s_left_blue   (s_left_blue),
        .s_right_red   (s_right_red),
        .s_right_green (s_right_green),
        .s_right_blue  (s_right_blue),
        .image_width   (image_width_reg),
        .space_ok      (space_ok),
        .push_n        (push_n),
        .push_job      (push_job)
    );

    smc_job_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_n     (push_n),
        .push_job   (push_job),
        .space_ok   (space_ok),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop)
    );

    smc_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .disparity     (disparity_reg),
        .head_valid    (head_valid),
        .head_job      (head_job),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_match_cost  (m_match_cost),
        .m_cost_column (m_cost_column),
        .m_row_done    (m_row_done)
    );

endmodule
